/* rtl/mrrc_pkg.sv */
// Package for the Modbus RTU response checker.
// Holds the item and result types, function codes, status codes and the CRC byte step.
// No dependencies.
package mrrc_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  FC_READ    = 8'h03;
    localparam logic [7:0]  FC_WRITE   = 8'h06;
    localparam int          FC_EXC_BIT = 7;
    localparam int          HDR_BYTES  = 5;
    localparam int          LEN_W      = 9;
    localparam int          RES_W      = 68;
    localparam int          OUT_DATA_W = 72;

    typedef enum logic [2:0] {
        ST_READ_OK   = 3'd0,
        ST_WRITE_OK  = 3'd1,
        ST_EXCEPTION = 3'd2,
        ST_CRC_ERROR = 3'd3,
        ST_TOO_SHORT = 3'd4,
        ST_OTHER     = 3'd5
    } status_t;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] rx_byte;
    } in_item_t;

    // packed msb first: status lands in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       exc_code;
        logic [15:0]      register_addr;
        logic [15:0]      data_value;
        logic [7:0]       function_code;
        logic [7:0]       slave_addr;
        status_t          status;
    } result_t;

    // one byte of CRC-16/MODBUS, reflected, lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/mrrc_in_reg.sv */
// Input register of the response checker: one item of storage on the slave side.
// Depends on mrrc_pkg for the item type.
module mrrc_in_reg
    import mrrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    input  logic     out_busy,
    output logic     advance,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // a byte that makes no result never waits on the output side
    assign advance    = valid_reg && (!item_reg.frame_end || !out_busy);
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

/* rtl/mrrc_frame_proc.sv */
// Frame state of the response checker: CRC with two-byte hold-back, header bytes,
// byte count, and the classification at frame end. Depends on mrrc_pkg.
module mrrc_frame_proc
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  in_item_t    item,
    input  logic [15:0] pending_register,
    output logic        res_valid,
    output result_t     result
);

    localparam int              LimInt    = (MAX_FRAME_BYTES > 511) ? 511 : MAX_FRAME_BYTES;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LimInt);

    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      crc_upd;
    logic [7:0]       dly0_reg;
    logic [7:0]       dly1_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] cnt_upd;
    logic [7:0]       hdr_reg [HDR_BYTES];
    logic [7:0]       hdr_upd [HDR_BYTES];
    logic [15:0]      rx_crc;
    result_t          res;

    always_comb
    begin
        crc_upd = (cnt_reg >= LEN_W'(2)) ? crc_feed(crc_reg, dly1_reg) : crc_reg;
        cnt_upd = (cnt_reg < LEN_LIMIT) ? cnt_reg + LEN_W'(1) : cnt_reg;
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            hdr_upd[k] = (cnt_reg == LEN_W'(k)) ? item.rx_byte : hdr_reg[k];
        end
    end

    assign rx_crc   = {item.rx_byte, dly0_reg};
    assign crc_next = item.frame_end ? CRC_INIT : crc_upd;

    always_comb
    begin
        res              = '0;
        res.status       = ST_TOO_SHORT;
        res.frame_length = cnt_upd;
        if (cnt_upd >= LEN_W'(HDR_BYTES))
        begin
            res.slave_addr    = hdr_upd[0];
            res.function_code = hdr_upd[1];
            priority if (rx_crc != crc_upd)
            begin
                res.status = ST_CRC_ERROR;
            end
            else if (hdr_upd[1] == FC_READ)
            begin
                res.status        = ST_READ_OK;
                res.data_value    = {hdr_upd[3], hdr_upd[4]};
                res.register_addr = pending_register;
            end
            else if (hdr_upd[1] == FC_WRITE)
            begin
                res.status        = ST_WRITE_OK;
                res.register_addr = {hdr_upd[2], hdr_upd[3]};
            end
            else if (hdr_upd[1][FC_EXC_BIT])
            begin
                res.status   = ST_EXCEPTION;
                res.exc_code = hdr_upd[2];
            end
            else
            begin
                res.status = ST_OTHER;
            end
        end
    end

    assign res_valid = advance && item.frame_end;
    assign result    = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            dly0_reg <= 8'h00;
            dly1_reg <= 8'h00;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            crc_reg  <= crc_next;
            dly0_reg <= item.frame_end ? 8'h00 : item.rx_byte;
            dly1_reg <= item.frame_end ? 8'h00 : dly0_reg;
            cnt_reg  <= item.frame_end ? '0 : cnt_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < HDR_BYTES; k++)
            begin
                hdr_reg[k] <= hdr_upd[k];
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (cnt_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after frame end");

    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LEN_LIMIT)
        else $error("byte count above limit");

    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_TOO_SHORT) |->
            (res.frame_length < LEN_W'(HDR_BYTES) && res.slave_addr == 8'h00))
        else $error("too_short result inconsistent with length");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(cnt_reg) && $stable(crc_reg)))
        else $error("frame state moved without an item");
`endif

endmodule

/* rtl/mrrc_out_reg.sv */
// Result register of the response checker on the master side.
// Depends on mrrc_pkg for the result type.
module mrrc_out_reg
    import mrrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    m_tready,
    output logic    m_tvalid,
    output result_t m_result,
    output logic    out_busy
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // load only comes when the slot is empty or being taken
    assign valid_next = load ? 1'b1 : (valid_reg && !m_tready);
    assign m_tvalid   = valid_reg;
    assign m_result   = res_reg;
    assign out_busy   = valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (res_reg.status <= ST_OTHER))
        else $error("status code out of range");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && m_tready && !load) |=> !valid_reg)
        else $error("taken result still shown");
`endif

endmodule

/* rtl/modbus_rtu_response_checker_core.sv */
// A frame's last byte passes the input register, then the result register, to reach m_tvalid.
// Throughput: one byte per cycle; bytes with no result never stall, and a frame-end byte
// waits only while the previous result sits untaken in the output register.
// Reset (rst_n low, async): empty input and output registers, CRC 0xFFFF, count zero,
// pending_register zero. Top level; depends on mrrc_pkg and the mrrc_* modules.
module modbus_rtu_response_checker_core
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,   // pending_register
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,     // rx_byte
    input  logic                  s_tlast,     // frame_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], slave_addr[10:3], function_code[18:11], data_value[34:19],
    // register_addr[50:35], exc_code[58:51], frame_length[67:59], zero[71:68]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic        pend_we;
    logic [15:0] pend_reg;
    in_item_t    s_item;
    in_item_t    item;
    logic        advance;
    logic        out_busy;
    logic        res_valid;
    result_t     result;
    result_t     m_result;

    assign pend_we          = cfg_we;
    assign s_item.rx_byte   = s_tdata;
    assign s_item.frame_end = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 16'h0000;
        end
        else if (pend_we)
        begin
            pend_reg <= cfg_wdata;
        end
    end

    mrrc_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .out_busy (out_busy),
        .advance  (advance),
        .item     (item)
    );

    mrrc_frame_proc #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_proc (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .item             (item),
        .pending_register (pend_reg),
        .res_valid        (res_valid),
        .result           (result)
    );

    mrrc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_result (m_result),
        .out_busy (out_busy)
    );

    assign m_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, m_result};

endmodule
